// ----- src/bdc_pkg.sv -----
// ----------------------------------------------------------------------------
// bdc_pkg: shared types and constants for the button debouncer
// Counter widths, register defaults, config and result structs, register map.
// ----------------------------------------------------------------------------
package bdc_pkg;

    // elapsed-time counters and click counter widths
    localparam int TIME_BITS  = 16;
    localparam int CLICK_BITS = 8;

    // configuration register widths
    localparam int SETTLE_W = 8;
    localparam int GAP_W    = 16;
    localparam int LONG_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // compare width wide enough for both counters and thresholds
    localparam int CMP_BITS = (TIME_BITS > LONG_W) ? TIME_BITS : LONG_W;

    localparam int TOTAL_W = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    typedef logic [TIME_BITS-1:0]  t_time;
    typedef logic [CLICK_BITS-1:0] t_clicks;
    typedef logic [CMP_BITS-1:0]   t_cmp;

    // register defaults
    localparam logic [SETTLE_W-1:0] DEF_SETTLE = 8'd10;
    localparam logic [GAP_W-1:0]    DEF_GAP    = 16'd300;
    localparam logic [LONG_W-1:0]   DEF_LONG   = 16'd2000;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETTLE = 2'd0,
        REG_GAP    = 2'd1,
        REG_LONG   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [SETTLE_W-1:0] settle_ticks;
        logic [GAP_W-1:0]    click_gap_ticks;
        logic [LONG_W-1:0]   long_press_ticks;
    } t_cfg;

    typedef struct packed {
        logic               stable_level;
        logic [TOTAL_W-1:0] click_total;
        logic               click_report;
        logic               long_press_event;
        logic               released_event;
        logic               pressed_event;
    } t_result;

endpackage

// ----- src/bdc_tick.sv -----
// ----------------------------------------------------------------------------
// bdc_tick: debounce and event state for one millisecond tick
// Holds the debounce/press/release/click state; the result of the tick is
// combinational from the current state and pin, state advances on i_step.
// ----------------------------------------------------------------------------
module bdc_tick (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_pin,
    input  bdc_pkg::t_cfg    i_cfg,
    output bdc_pkg::t_result o_res
);

    logic                          r_deb, n_deb;
    logic                          r_pending, n_pending;
    logic [bdc_pkg::SETTLE_W-1:0]  r_pend, n_pend;
    bdc_pkg::t_time                r_press, n_press;
    bdc_pkg::t_time                r_rel, n_rel;
    logic                          r_long, n_long;
    bdc_pkg::t_clicks              r_clicks, n_clicks;
    logic [bdc_pkg::LONG_W-1:0]    thr;

    always_comb begin
        n_deb     = r_deb;
        n_pending = r_pending;
        n_pend    = r_pend;
        n_long    = r_long;
        n_clicks  = r_clicks;
        n_press   = (r_press == '1) ? r_press : r_press + 1'b1;
        n_rel     = (r_rel == '1) ? r_rel : r_rel + 1'b1;
        o_res     = '0;

        if (r_pending) begin
            n_pend = (r_pend == '1) ? r_pend : r_pend + 1'b1;
            if (n_pend >= i_cfg.settle_ticks) begin
                if (i_pin != r_deb) begin
                    if (!i_pin) begin
                        o_res.pressed_event = 1'b1;
                        n_press = '0;
                        n_long  = 1'b0;
                    end else begin
                        o_res.released_event = 1'b1;
                        n_rel    = '0;
                        n_clicks = (r_clicks == '1) ? r_clicks : r_clicks + 1'b1;
                    end
                end
                n_deb     = i_pin;
                n_pending = 1'b0;
            end
        end else if (i_pin != r_deb) begin
            n_pending = 1'b1;
            n_pend    = '0;
        end

        // zero threshold means the default
        thr = (i_cfg.long_press_ticks == '0) ? bdc_pkg::DEF_LONG : i_cfg.long_press_ticks;
        if (!n_deb && !n_long &&
            (bdc_pkg::t_cmp'(n_press) >= bdc_pkg::t_cmp'(thr))) begin
            n_long = 1'b1;
            o_res.long_press_event = 1'b1;
        end

        if ((n_clicks != '0) && n_deb &&
            (bdc_pkg::t_cmp'(n_rel) > bdc_pkg::t_cmp'(i_cfg.click_gap_ticks))) begin
            o_res.click_report = 1'b1;
            o_res.click_total  = (32'(n_clicks) > 32'd255) ? 8'd255
                                                          : bdc_pkg::TOTAL_W'(n_clicks);
            n_clicks = '0;
        end

        o_res.stable_level = n_deb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb     <= 1'b1;
            r_pending <= 1'b0;
            r_pend    <= '0;
            r_press   <= '0;
            r_rel     <= '0;
            r_long    <= 1'b0;
            r_clicks  <= '0;
        end else if (i_step) begin
            r_deb     <= n_deb;
            r_pending <= n_pending;
            r_pend    <= n_pend;
            r_press   <= n_press;
            r_rel     <= n_rel;
            r_long    <= n_long;
            r_clicks  <= n_clicks;
        end
    end

endmodule

// ----- src/button_debounce_click_longpress.sv -----
// ----------------------------------------------------------------------------
// button_debounce_click_longpress: debounced button with click/long-press events
// One tick transaction in, one event transaction out, full stream throughput while m_axis is not stalled.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata[0] pin_level (0 pressed)
// m_axis    out  m_axis_tvalid/tready        tdata: events, click_total, level
// cfg       in   i_cfg_valid/o_cfg_ready     i_cfg_index, i_cfg_data
//
// One tick transaction per cycle while the result is not stalled; a tick passes
// the input register, then the event logic into the result register.
// Reset (synchronous, active low) restores the register defaults 10/300/2000
// and a released, idle button.
// A stalled result holds in the result register; the input register still
// takes one more tick, then s_axis_tready drops until the result leaves.
// Config writes are always ready and apply to the next tick evaluated.
module button_debounce_click_longpress (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input ticks
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bdc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [0] pin_level, rest zero
    // events
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] pressed_event [1] released_event [2] long_press_event [3] click_report
    // [11:4] click_total [12] stable_level, [15:13] zero
    output logic [bdc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bdc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bdc_pkg::CFG_W-1:0]           i_cfg_data
);

    bdc_pkg::t_cfg    r_cfg;
    logic             r_in_valid;
    logic             r_in_pin;
    logic             r_out_valid;
    bdc_pkg::t_result r_out;
    bdc_pkg::t_result res;
    logic             out_free;
    logic             step;

    assign o_cfg_ready = 1'b1;

    // config registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks     <= bdc_pkg::DEF_SETTLE;
            r_cfg.click_gap_ticks  <= bdc_pkg::DEF_GAP;
            r_cfg.long_press_ticks <= bdc_pkg::DEF_LONG;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bdc_pkg::REG_SETTLE: r_cfg.settle_ticks <= i_cfg_data[bdc_pkg::SETTLE_W-1:0];
                bdc_pkg::REG_GAP:    r_cfg.click_gap_ticks  <= i_cfg_data;
                bdc_pkg::REG_LONG:   r_cfg.long_press_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the result slot is free when empty or draining this cycle
    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_pin <= s_axis_tdata[0];
        end
    end

    bdc_tick u_tick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_pin   (r_in_pin),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = bdc_pkg::OUT_TDATA_W'(r_out);

    // a tick never reports both edges
    a_one_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.pressed_event && r_out.released_event))
        else $error("press and release in one tick");

    // a press edge leaves the button pressed, a release leaves it released
    a_edge_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((!r_out.pressed_event || !r_out.stable_level) &&
                         (!r_out.released_event || r_out.stable_level)))
        else $error("edge event disagrees with stable level");

    // long press only while held, click report only while released
    a_hold_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((!r_out.long_press_event || !r_out.stable_level) &&
                         (!r_out.click_report || r_out.stable_level)))
        else $error("long press or click report at wrong level");

    // count is zero outside a report and nonzero with one
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.click_report == (r_out.click_total != '0)))
        else $error("click total inconsistent with report");

    // a stalled result is not overwritten
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");

endmodule
